[design/svms_pkg.sv]
// Package for the self-vehicle match score block: fixed-point constants,
// CORDIC arctangent table and configuration register indexes.
// No dependencies.
package svms_pkg;

    localparam int HOST_WIDTH_CM_DEF  = 190;
    localparam int HOST_LENGTH_CM_DEF = 480;

    // Pipeline shape
    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 15;
    localparam int LATENCY      = 71;

    // CORDIC vector (Q30) and angle (Q29) widths
    localparam int W_XY = 34;
    localparam int W_Z  = 33;

    // Configuration register indexes
    localparam logic [2:0] CFG_W_LON     = 3'd0;
    localparam logic [2:0] CFG_W_LAT     = 3'd1;
    localparam logic [2:0] CFG_W_HEADING = 3'd2;
    localparam logic [2:0] CFG_W_SPEED   = 3'd3;
    localparam logic [2:0] CFG_W_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_W_LENGTH  = 3'd5;
    localparam logic [2:0] CFG_THRESHOLD = 3'd6;

    localparam logic [47:0] SCORE_MAX = 48'hFFFF_FFFF_FFFF;

    // Fixed-point conversion factors
    localparam logic signed [40:0]     YAW_K     = 41'sd9387341;
    localparam logic [61:0]            LAT_K     = 62'd4024455254;
    localparam logic signed [47:0]     UNITS_K   = 48'sd7676039227;
    localparam logic signed [62:0]     RAD_K     = 63'sd300394896;
    localparam logic signed [W_XY-1:0] CORDIC_X0 = 34'sd652032874;

    // atan(2^-k) in Q29 radians
    function automatic logic signed [W_Z-1:0] atan_q29(input int k);
        logic signed [W_Z-1:0] v;
        unique case (k)
            0:  v = 33'sd421657428;
            1:  v = 33'sd248918915;
            2:  v = 33'sd131521918;
            3:  v = 33'sd66762579;
            4:  v = 33'sd33510843;
            5:  v = 33'sd16771758;
            6:  v = 33'sd8387925;
            7:  v = 33'sd4194219;
            8:  v = 33'sd2097141;
            9:  v = 33'sd1048575;
            10: v = 33'sd524288;
            11: v = 33'sd262144;
            12: v = 33'sd131072;
            13: v = 33'sd65536;
            14: v = 33'sd32768;
            15: v = 33'sd16384;
            16: v = 33'sd8192;
            17: v = 33'sd4096;
            18: v = 33'sd2048;
            19: v = 33'sd1024;
            20: v = 33'sd512;
            21: v = 33'sd256;
            22: v = 33'sd128;
            23: v = 33'sd64;
            24: v = 33'sd32;
            25: v = 33'sd16;
            26: v = 33'sd8;
            27: v = 33'sd4;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/self_vehicle_match_score.sv]
// Top level of the self-vehicle match score block.
// Depends on svms_pkg.

// One report is taken on every clock at which start is high; busy is always
// low. The result appears on o_match_score / o_is_self with o_valid high for
// one cycle, in order. The pipeline depth is set by the heading path: two
// 28-step CORDIC pipelines (rotation for tan/cos, then vectoring for atan)
// plus the conversion multipliers and the final weighting and summing stages.
// The speed square root is a 15-stage pipeline running alongside. There is no
// backpressure: o_valid results must be taken when shown. Write the weights
// and threshold only while no report is in flight.
module self_vehicle_match_score #(
    parameter int HOST_WIDTH_CM  = svms_pkg::HOST_WIDTH_CM_DEF,
    parameter int HOST_LENGTH_CM = svms_pkg::HOST_LENGTH_CM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_obs_lon,
    input  logic signed [30:0] i_obs_lat,
    input  logic [14:0]        i_obs_heading,
    input  logic [12:0]        i_obs_speed,
    input  logic [9:0]         i_obs_width,
    input  logic [11:0]        i_obs_length,
    input  logic signed [31:0] i_host_lon,
    input  logic signed [30:0] i_host_lat,
    input  logic signed [15:0] i_host_yaw,
    input  logic signed [14:0] i_host_vel_long,
    input  logic signed [14:0] i_host_vel_lat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    output logic               o_valid,
    output logic [47:0]        o_match_score,
    output logic               o_is_self
);

    localparam int NR  = svms_pkg::CORDIC_STEPS;
    localparam int NS  = svms_pkg::SQRT_STEPS;
    localparam int WXY = svms_pkg::W_XY;
    localparam int WZ  = svms_pkg::W_Z;

    typedef struct packed {
        logic [31:0] dlon;
        logic [30:0] dlat;
        logic [9:0]  dw;
        logic [11:0] dl;
        logic [14:0] obs_heading;
        logic [12:0] obs_speed;
    } t_side;

    // Configuration registers
    logic [15:0] r_w_lon, r_w_lat, r_w_hdg, r_w_spd, r_w_wid, r_w_len;
    logic [47:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_lon <= '0;
            r_w_lat <= '0;
            r_w_hdg <= '0;
            r_w_spd <= '0;
            r_w_wid <= '0;
            r_w_len <= '0;
            r_thr   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svms_pkg::CFG_W_LON:     r_w_lon <= i_cfg_data[15:0];
                svms_pkg::CFG_W_LAT:     r_w_lat <= i_cfg_data[15:0];
                svms_pkg::CFG_W_HEADING: r_w_hdg <= i_cfg_data[15:0];
                svms_pkg::CFG_W_SPEED:   r_w_spd <= i_cfg_data[15:0];
                svms_pkg::CFG_W_WIDTH:   r_w_wid <= i_cfg_data[15:0];
                svms_pkg::CFG_W_LENGTH:  r_w_len <= i_cfg_data[15:0];
                svms_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data
    logic [svms_pkg::LATENCY:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[svms_pkg::LATENCY-1:1], start};
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld[svms_pkg::LATENCY];

    // ---------------------------------------------------------------- stage 1
    logic [30:0]        n_lat_abs;
    logic               n_lat_neg;
    logic [29:0]        n_lat_fold;
    logic signed [32:0] n_dlon_s;
    logic signed [31:0] n_dlat_s;
    logic signed [10:0] n_dw_s;
    logic signed [12:0] n_dl_s;
    logic signed [29:0] n_sql, n_sqt;
    t_side              n_side;

    always_comb begin
        n_lat_abs  = i_host_lat[30] ? 31'(-i_host_lat) : 31'(i_host_lat);
        n_lat_neg  = n_lat_abs > 31'd900000000;
        // fold latitude beyond 90 degrees, cosine sign flips
        n_lat_fold = n_lat_neg ? 30'(31'd1800000000 - n_lat_abs) : n_lat_abs[29:0];
        n_dlon_s   = 33'(i_host_lon) - 33'(i_obs_lon);
        n_dlat_s   = 32'(i_host_lat) - 32'(i_obs_lat);
        n_dw_s     = 11'(HOST_WIDTH_CM) - $signed({1'b0, i_obs_width});
        n_dl_s     = 13'(HOST_LENGTH_CM) - $signed({1'b0, i_obs_length});
        n_side.dlon = n_dlon_s[32] ? 32'(-n_dlon_s) : n_dlon_s[31:0];
        n_side.dlat = n_dlat_s[31] ? 31'(-n_dlat_s) : n_dlat_s[30:0];
        n_side.dw   = n_dw_s[10] ? 10'(-n_dw_s) : n_dw_s[9:0];
        n_side.dl   = n_dl_s[12] ? 12'(-n_dl_s) : n_dl_s[11:0];
        n_side.obs_heading = i_obs_heading;
        n_side.obs_speed   = i_obs_speed;
        n_sql = 30'(i_host_vel_long) * 30'(i_host_vel_long);
        n_sqt = 30'(i_host_vel_lat) * 30'(i_host_vel_lat);
    end

    logic signed [40:0] r1_pyaw;
    logic [29:0]        r1_lat_a;
    logic [28:0]        r1_sql, r1_sqt;
    logic [33:1]        r_neg;
    logic [65:3]        r_ruler;
    t_side              r_side [1:67];

    always_ff @(posedge i_clk) begin
        r1_pyaw   <= 41'(i_host_yaw) * svms_pkg::YAW_K;
        r1_lat_a  <= n_lat_fold;
        r1_sql    <= n_sql[28:0];
        r1_sqt    <= n_sqt[28:0];
        r_neg[1]  <= n_lat_neg;
        r_side[1] <= n_side;
        r_neg[33:2]   <= r_neg[32:1];
        for (int s = 2; s <= 67; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic signed [40:0] n_yaw_rnd;
    logic signed [17:0] n_h0;
    logic [14:0]        n_h;

    always_comb begin
        n_yaw_rnd = (r1_pyaw + 41'sd8388608) >>> 24;
        n_h0      = 18'sd7200 - 18'(n_yaw_rnd);
        priority if (n_h0 > 18'sd28800) begin
            n_h = 15'(n_h0 - 18'sd28800);
        end else if (n_h0 < 18'sd0) begin
            n_h = 15'(n_h0 + 18'sd28800);
        end else begin
            n_h = n_h0[14:0];
        end
    end

    logic [14:0] r2_h;
    logic [61:0] r2_lprod;
    logic [29:0] r_sn [0:NS];
    logic [29:0] r_sr [0:NS];

    always_ff @(posedge i_clk) begin
        r2_h     <= n_h;
        r2_lprod <= 62'(r1_lat_a) * svms_pkg::LAT_K;
        r_sn[0]  <= 30'(r1_sql) + 30'(r1_sqt);
        r_sr[0]  <= '0;
    end

    // Speed: digit-by-digit square root, one result bit per stage
    for (genvar j = 0; j < NS; j++) begin : g_sqrt
        localparam logic [29:0] B = 30'(1) << (2 * (NS - 1 - j));
        always_ff @(posedge i_clk) begin
            if (r_sn[j] >= r_sr[j] + B) begin
                r_sn[j+1] <= r_sn[j] - (r_sr[j] + B);
                r_sr[j+1] <= (r_sr[j] >> 1) + B;
            end else begin
                r_sn[j+1] <= r_sn[j];
                r_sr[j+1] <= r_sr[j] >> 1;
            end
        end
    end

    logic [14:0]        r18_spd;
    logic signed [15:0] n_sd_s;
    logic [14:0]        r_sd [19:67];

    assign n_sd_s = $signed({1'b0, r18_spd}) - $signed({3'b000, r_side[18].obs_speed});

    always_ff @(posedge i_clk) begin
        // round half up on the remainder
        r18_spd   <= (r_sn[NS] > r_sr[NS]) ? 15'(r_sr[NS] + 30'd1) : r_sr[NS][14:0];
        r_sd[19]  <= n_sd_s[15] ? 15'(-n_sd_s) : n_sd_s[14:0];
        for (int s = 20; s <= 67; s++) begin
            r_sd[s] <= r_sd[s-1];
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic signed [16:0] n_tt, n_tm, n_t;
    logic [62:0]        n_zl_sum;

    always_comb begin
        n_tt = 17'sd14400 - $signed({2'b00, r2_h});
        priority if (n_tt < 17'sd0) begin
            n_tm = n_tt + 17'sd14400;
        end else if (n_tt >= 17'sd14400) begin
            n_tm = n_tt - 17'sd14400;
        end else begin
            n_tm = n_tt;
        end
        n_t      = n_tm - 17'sd7200;
        n_zl_sum = 63'(r2_lprod) + 63'd2147483648;
    end

    logic signed [13:0] r3_t;
    logic [29:0]        r3_zl;

    always_ff @(posedge i_clk) begin
        r3_t    <= 14'(n_t);
        r3_zl   <= n_zl_sum[61:32];
        r_ruler <= {r_ruler[64:3], (r2_h <= 15'd14400)};
    end

    // ---------------------------------------------------------------- stage 4
    logic signed [47:0] r4_tp;
    logic [29:0]        r4_zl;

    always_ff @(posedge i_clk) begin
        r4_tp <= 48'(r3_t) * svms_pkg::UNITS_K;
        r4_zl <= r3_zl;
    end

    // ------------------------------------------------- stages 5..33: rotation
    logic signed [47:0]    n_zt_rnd;
    logic signed [WXY-1:0] r_tx [0:NR];
    logic signed [WXY-1:0] r_ty [0:NR];
    logic signed [WZ-1:0]  r_tz [0:NR];
    logic signed [WXY-1:0] r_lx [0:NR];
    logic signed [WXY-1:0] r_ly [0:NR];
    logic signed [WZ-1:0]  r_lz [0:NR];

    assign n_zt_rnd = (r4_tp + 48'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        r_tx[0] <= svms_pkg::CORDIC_X0;
        r_ty[0] <= '0;
        r_tz[0] <= n_zt_rnd[WZ-1:0];
        r_lx[0] <= svms_pkg::CORDIC_X0;
        r_ly[0] <= '0;
        r_lz[0] <= $signed({3'b000, r4_zl});
    end

    for (genvar k = 0; k < NR; k++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!r_tz[k][WZ-1]) begin
                r_tx[k+1] <= r_tx[k] - (r_ty[k] >>> k);
                r_ty[k+1] <= r_ty[k] + (r_tx[k] >>> k);
                r_tz[k+1] <= r_tz[k] - svms_pkg::atan_q29(k);
            end else begin
                r_tx[k+1] <= r_tx[k] + (r_ty[k] >>> k);
                r_ty[k+1] <= r_ty[k] - (r_tx[k] >>> k);
                r_tz[k+1] <= r_tz[k] + svms_pkg::atan_q29(k);
            end
            if (!r_lz[k][WZ-1]) begin
                r_lx[k+1] <= r_lx[k] - (r_ly[k] >>> k);
                r_ly[k+1] <= r_ly[k] + (r_lx[k] >>> k);
                r_lz[k+1] <= r_lz[k] - svms_pkg::atan_q29(k);
            end else begin
                r_lx[k+1] <= r_lx[k] + (r_ly[k] >>> k);
                r_ly[k+1] <= r_ly[k] - (r_lx[k] >>> k);
                r_lz[k+1] <= r_lz[k] + svms_pkg::atan_q29(k);
            end
        end
    end

    // --------------------------------------------------------------- stage 34
    logic signed [WXY-1:0] n_cl;
    logic signed [63:0]    r34_yp;
    logic signed [WXY-1:0] r34_ct;

    assign n_cl = r_neg[33] ? -r_lx[NR] : r_lx[NR];

    always_ff @(posedge i_clk) begin
        r34_yp <= 64'($signed(n_cl[31:0])) * 64'($signed(r_ty[NR][31:0]));
        r34_ct <= r_tx[NR];
    end

    // ------------------------------------------------ stages 35..63: vectoring
    logic signed [63:0]    n_y64;
    logic signed [WXY-1:0] r_ax [0:NR];
    logic signed [WXY-1:0] r_ay [0:NR];
    logic signed [WZ-1:0]  r_az [0:NR];
    logic                  r_zero [0:NR];

    assign n_y64 = (r34_yp + 64'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        r_ax[0]   <= r34_ct;
        r_ay[0]   <= n_y64[WXY-1:0];
        r_az[0]   <= '0;
        r_zero[0] <= (r34_ct == '0) && (n_y64 == '0);
    end

    for (genvar k = 0; k < NR; k++) begin : g_vec
        always_ff @(posedge i_clk) begin
            r_zero[k+1] <= r_zero[k];
            if (r_ay[k][WXY-1]) begin
                r_ax[k+1] <= r_ax[k] - (r_ay[k] >>> k);
                r_ay[k+1] <= r_ay[k] + (r_ax[k] >>> k);
                r_az[k+1] <= r_az[k] - svms_pkg::atan_q29(k);
            end else begin
                r_ax[k+1] <= r_ax[k] + (r_ay[k] >>> k);
                r_ay[k+1] <= r_ay[k] - (r_ax[k] >>> k);
                r_az[k+1] <= r_az[k] + svms_pkg::atan_q29(k);
            end
        end
    end

    // ---------------------------------------------------------- stages 64..67
    logic signed [WZ-1:0] n_zsel;
    logic signed [62:0]   r64_dp;
    logic signed [62:0]   n_deal;
    logic signed [16:0]   r65_deal;
    logic signed [18:0]   n_hd, n_d1s, n_d2s;
    logic [17:0]          r66_d1;
    logic [14:0]          r67_dh;

    always_comb begin
        // both vector parts zero gives angle zero
        n_zsel = r_az[NR];
        if (r_zero[NR]) begin
            n_zsel = '0;
        end
        n_deal = (r64_dp + 63'sd17592186044416) >>> 45;
        n_hd   = (r_ruler[65] ? 19'sd7200 : 19'sd21600) - 19'(r65_deal);
        n_d1s  = n_hd - $signed({4'b0000, r_side[65].obs_heading});
        n_d2s  = $signed({1'b0, r66_d1}) - 19'sd28800;
    end

    always_ff @(posedge i_clk) begin
        r64_dp   <= 63'(n_zsel) * svms_pkg::RAD_K;
        r65_deal <= n_deal[16:0];
        r66_d1   <= n_d1s[18] ? 18'(-n_d1s) : n_d1s[17:0];
        // wrap heading difference at 180 degrees
        if (r66_d1 > 18'd14400) begin
            r67_dh <= n_d2s[18] ? 15'(-n_d2s) : n_d2s[14:0];
        end else begin
            r67_dh <= r66_d1[14:0];
        end
    end

    // ---------------------------------------------------------- stages 68..71
    logic [47:0] r68_p_lon, r68_p_lat, r68_p_hdg, r68_p_spd, r68_p_wid, r68_p_len;
    logic [48:0] r69_s0, r69_s1, r69_s2;
    logic [50:0] n_tot;
    logic [47:0] r70_score;
    logic [47:0] r_out_score;
    logic        r_out_self;

    assign n_tot = 51'(r69_s0) + 51'(r69_s1) + 51'(r69_s2);

    always_ff @(posedge i_clk) begin
        r68_p_lon <= 48'(r_side[67].dlon) * 48'(r_w_lon);
        r68_p_lat <= 48'(r_side[67].dlat) * 48'(r_w_lat);
        r68_p_hdg <= 48'(r67_dh) * 48'(r_w_hdg);
        r68_p_spd <= 48'(r_sd[67]) * 48'(r_w_spd);
        r68_p_wid <= 48'(r_side[67].dw) * 48'(r_w_wid);
        r68_p_len <= 48'(r_side[67].dl) * 48'(r_w_len);
        r69_s0    <= 49'(r68_p_lon) + 49'(r68_p_lat);
        r69_s1    <= 49'(r68_p_hdg) + 49'(r68_p_spd);
        r69_s2    <= 49'(r68_p_wid) + 49'(r68_p_len);
        r70_score <= (n_tot > 51'(svms_pkg::SCORE_MAX)) ? svms_pkg::SCORE_MAX
                                                       : n_tot[47:0];
        r_out_score <= r70_score;
        r_out_self  <= r70_score < r_thr;
    end

    assign o_match_score = r_out_score;
    assign o_is_self     = r_out_self;

endmodule

[design/svms_check.sv]
// Port-level checker for self_vehicle_match_score, bound to the top level.
// Depends on svms_pkg.
module svms_check #(
    parameter int LAT = svms_pkg::LATENCY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [47:0] o_match_score,
    input logic        o_is_self,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_idx,
    input logic [47:0] i_cfg_data
);

    // shadow of the threshold register
    logic [47:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we && (i_cfg_idx == svms_pkg::CFG_THRESHOLD)) begin
            r_thr <= i_cfg_data;
        end
    end

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a transaction LAT cycles earlier");

    a_self_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_self == (o_match_score < r_thr)))
        else $error("self flag disagrees with score and threshold");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind self_vehicle_match_score svms_check u_svms_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_match_score (o_match_score),
    .o_is_self     (o_is_self),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_data    (i_cfg_data)
);

[test/svms_checker.sv]
`timescale 1ns / 1ps
// Checker for the self-vehicle match score block: tracks register writes,
// predicts the score and self flag of each accepted report, compares results.
// Depends on svms_pkg for the register indexes.
module svms_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_obs_lon,
    input  logic signed [30:0] i_obs_lat,
    input  logic [14:0]        i_obs_heading,
    input  logic [12:0]        i_obs_speed,
    input  logic [9:0]         i_obs_width,
    input  logic [11:0]        i_obs_length,
    input  logic signed [31:0] i_host_lon,
    input  logic signed [30:0] i_host_lat,
    input  logic signed [15:0] i_host_yaw,
    input  logic signed [14:0] i_host_vel_long,
    input  logic signed [14:0] i_host_vel_lat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    input  logic               o_valid,
    input  logic [47:0]        o_match_score,
    input  logic               o_is_self,
    output int                 n_pending,
    output int                 n_errors
);

    localparam int  HOST_W   = 190;
    localparam int  HOST_L   = 480;
    localparam int  N_ITER   = 28;
    localparam longint INV_GAIN = 652032874;
    localparam longint ATAN_TAB [N_ITER] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4};
    localparam logic [47:0] SAT = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [47:0] score;
        logic        self_flag;
    } t_score;

    t_score score_q[$];
    logic [15:0] w_lon, w_lat, w_head, w_speed, w_width, w_length;
    logic [47:0] thr;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void rotate(input longint z_in, output longint c, output longint s);
        longint x, y, z, nx;
        x = INV_GAIN;
        y = 0;
        z = z_in;
        for (int i = 0; i < N_ITER; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
            end
            x = nx;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint vector_angle(longint y_in, longint x_in);
        longint x, y, z, nx;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < N_ITER; i++) begin
            if (y < 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TAB[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TAB[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint speed_of(longint vl, longint vt);
        logic [63:0] n, r, b;
        n = vl * vl + vt * vt;
        r = 0;
        b = 64'd1 << 40;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b); r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return (n > r) ? longint'(r + 1) : longint'(r);
    endfunction

    // compass heading of the host corrected for latitude, 0.0125 deg units
    function automatic longint corrected_heading(longint yaw, longint lat);
        longint h, t, zt, zl, ct, st, cl, sl, y, dev, a;
        logic [63:0] ua;
        bit folded;
        folded = 0;
        h = 7200 - rnd_shift(yaw * 64'sd9387341, 24);
        if (h > 28800) h -= 28800;
        else if (h < 0) h += 28800;
        t = 7200 - h;
        t = ((t + 7200) % 14400 + 14400) % 14400 - 7200;
        zt = rnd_shift(t * 64'sd7676039227, 16);
        rotate(zt, ct, st);
        a = mag(lat);
        if (a > 900000000) begin
            a = 1800000000 - a;
            folded = 1;
        end
        ua = (64'(a) * 64'd4024455254 + (64'd1 << 31)) >> 32;
        zl = longint'(ua);
        rotate(zl, cl, sl);
        if (folded) cl = -cl;
        y = rnd_shift(cl * st, 30);
        dev = rnd_shift(vector_angle(y, ct) * 64'sd300394896, 45);
        return ((h >= 0 && h <= 14400) ? 7200 : 21600) - dev;
    endfunction

    function automatic t_score predict_score();
        t_score r;
        longint dh, spd;
        logic [63:0] sum;
        dh = mag(corrected_heading(longint'(i_host_yaw), longint'(i_host_lat))
                 - longint'(i_obs_heading));
        if (dh > 14400) dh = mag(dh - 28800);
        spd = speed_of(longint'(i_host_vel_long), longint'(i_host_vel_lat));
        sum = 64'(mag(longint'(i_host_lon) - longint'(i_obs_lon))) * w_lon
            + 64'(mag(longint'(i_host_lat) - longint'(i_obs_lat))) * w_lat
            + 64'(dh) * w_head
            + 64'(mag(spd - longint'(i_obs_speed))) * w_speed
            + 64'(mag(longint'(HOST_W) - longint'(i_obs_width))) * w_width
            + 64'(mag(longint'(HOST_L) - longint'(i_obs_length))) * w_length;
        if (sum > 64'(SAT)) sum = 64'(SAT);
        r.score = sum[47:0];
        r.self_flag = (sum[47:0] < thr);
        return r;
    endfunction

    function automatic void mismatch(string what, logic [47:0] exp_v, logic [47:0] got_v);
        if (n_errors < 10)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
        n_errors++;
    endfunction

    initial begin
        n_errors = 0;
        n_pending = 0;
    end

    always @(posedge i_clk) begin
        t_score exp_r;
        if (!i_rst_n) begin
            {w_lon, w_lat, w_head, w_speed, w_width, w_length} <= '0;
            thr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    svms_pkg::CFG_W_LON:     w_lon    <= i_cfg_data[15:0];
                    svms_pkg::CFG_W_LAT:     w_lat    <= i_cfg_data[15:0];
                    svms_pkg::CFG_W_HEADING: w_head   <= i_cfg_data[15:0];
                    svms_pkg::CFG_W_SPEED:   w_speed  <= i_cfg_data[15:0];
                    svms_pkg::CFG_W_WIDTH:   w_width  <= i_cfg_data[15:0];
                    svms_pkg::CFG_W_LENGTH:  w_length <= i_cfg_data[15:0];
                    svms_pkg::CFG_THRESHOLD: thr      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid) begin
                if (score_q.size() == 0) begin
                    if (n_errors < 10) $display("result with no report pending");
                    n_errors++;
                end else begin
                    exp_r = score_q.pop_front();
                    if (o_match_score !== exp_r.score)
                        mismatch("match_score", exp_r.score, o_match_score);
                    if (o_is_self !== exp_r.self_flag)
                        mismatch("is_self", 48'(exp_r.self_flag), 48'(o_is_self));
                end
            end
            if (start && !busy) score_q.push_back(predict_score());
            n_pending <= score_q.size();
        end
    end
endmodule

[test/tb_self_vehicle_match_score.sv]
`timescale 1ns / 1ps
// Testbench top for the self-vehicle match score block: clock, reset,
// register phases and report stimulus. Depends on svms_pkg, self_vehicle_match_score and svms_checker.
module tb_self_vehicle_match_score;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN = svms_pkg::LATENCY + 20;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [31:0] i_obs_lon = '0;
    logic signed [30:0] i_obs_lat = '0;
    logic [14:0]        i_obs_heading = '0;
    logic [12:0]        i_obs_speed = '0;
    logic [9:0]         i_obs_width = '0;
    logic [11:0]        i_obs_length = '0;
    logic signed [31:0] i_host_lon = '0;
    logic signed [30:0] i_host_lat = '0;
    logic signed [15:0] i_host_yaw = '0;
    logic signed [14:0] i_host_vel_long = '0;
    logic signed [14:0] i_host_vel_lat = '0;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_idx = '0;
    logic [47:0]        i_cfg_data = '0;
    logic               o_valid;
    logic [47:0]        o_match_score;
    logic               o_is_self;
    int                 n_pending, n_errors;
    int                 cycles = 0;
    int                 burst_left = 0;

    always #5 i_clk = ~i_clk;

    self_vehicle_match_score uut (.*);
    svms_checker chk (.*);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic load_regs(input logic [15:0] wl, input logic [15:0] wa,
                             input logic [15:0] wh, input logic [15:0] ws,
                             input logic [15:0] ww, input logic [15:0] wn,
                             input logic [47:0] th);
        logic [47:0] vals [8];
        logic [2:0]  idxs [8];
        vals = '{48'(wl), 48'(wa), 48'(wh), 48'(ws), 48'(ww), 48'(wn), th,
                 48'({$urandom, $urandom})};
        idxs = '{svms_pkg::CFG_W_LON, svms_pkg::CFG_W_LAT, svms_pkg::CFG_W_HEADING,
                 svms_pkg::CFG_W_SPEED, svms_pkg::CFG_W_WIDTH, svms_pkg::CFG_W_LENGTH,
                 svms_pkg::CFG_THRESHOLD, CFG_UNUSED};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // hold until every result is in, then let the pipe drain
    task automatic wait_idle();
        while (n_pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic send(input longint olon, input longint olat, input longint ohd,
                        input longint ospd, input longint ow, input longint ol,
                        input longint hlon, input longint hlat, input longint yaw,
                        input longint vl, input longint vt);
        int gap;
        start           <= 1;
        i_obs_lon       <= olon[31:0];
        i_obs_lat       <= olat[30:0];
        i_obs_heading   <= ohd[14:0];
        i_obs_speed     <= ospd[12:0];
        i_obs_width     <= ow[9:0];
        i_obs_length    <= ol[11:0];
        i_host_lon      <= hlon[31:0];
        i_host_lat      <= hlat[30:0];
        i_host_yaw      <= yaw[15:0];
        i_host_vel_long <= vl[14:0];
        i_host_vel_lat  <= vt[14:0];
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            case ($urandom_range(0, 19))
                0:             gap = $urandom_range(5, 40);
                1:             begin burst_left = $urandom_range(10, 40); gap = 0; end
                2, 3, 4, 5, 6, 7, 8: gap = $urandom_range(1, 3);
                default:       gap = 0;
            endcase
        end
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic longint srand(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    task automatic send_random();
        longint hlon, hlat;
        if ($urandom_range(0, 3) == 0) begin
            // raw bit patterns, out of range included
            send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            hlon = srand(-1800000000, 1800000000);
            hlat = srand(-900000000, 900000000);
            send(hlon + srand(-2000, 2000), hlat + srand(-2000, 2000),
                 srand(0, 28800), srand(0, 8191), srand(100, 300), srand(300, 700),
                 hlon, hlat, srand(-25736, 25736),
                 srand(-16383, 16383), srand(-16383, 16383));
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random();
        start <= 0;
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset weights: every score zero, never below a zero threshold
        run_random(100);

        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  svms_pkg::SCORE_MAX);
        // field extremes
        send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(-2147483648, -1073741824, 32767, 8191, 1023, 4095,
             2147483647, 1073741823, 32767, 16383, 16383);
        send(2147483647, 1073741823, 28800, 0, 190, 480,
             -2147483648, -1073741824, -32768, -16384, -16384);
        send(1800000000, 900000000, 0, 8191, 1023, 4095,
             -1800000000, -900000000, -25736, -16383, -16383);
        // exact match of the host
        send(123456789, 456789012, 7200, 0, 190, 480, 123456789, 456789012,
             0, 0, 0);
        // vertical tangent, heading near 0 and 180 deg
        send(0, 0, 0, 0, 190, 480, 0, 300000000, 12868, 100, 0);
        send(0, 0, 14400, 0, 190, 480, 0, -300000000, -12868, 0, 100);
        send(0, 0, 0, 0, 190, 480, 0, 450000000, 12867, 3, 4);
        send(0, 0, 14400, 0, 190, 480, 0, 450000000, -12869, -3, -4);
        // latitude at and beyond the pole, vector near zero
        send(0, 900000000, 100, 0, 190, 480, 0, 900000000, 12868, 0, 0);
        send(0, -900000000, 28000, 0, 190, 480, 0, -900000000, 6434, 0, 0);
        send(0, 0, 100, 0, 190, 480, 0, 1000000000, 3000, 0, 0);
        send(0, 0, 20000, 0, 190, 480, 0, -1073741824, -20000, 0, 0);
        // heading wrap around 180 deg
        send(0, 0, 28799, 0, 190, 480, 0, 0, 12868, 0, 0);
        send(0, 0, 1, 0, 190, 480, 0, 0, -12868, 0, 0);
        send(0, 0, 0, 0, 190, 480, 0, 0, 25736, 0, 0);
        send(0, 0, 0, 0, 190, 480, 0, 0, -25736, 0, 0);
        start <= 0;
        wait_idle();

        // threshold zero: flag never set; saturation still reached
        load_regs(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 48'd0);
        send(-2147483648, -1073741824, 0, 0, 0, 0,
             2147483647, 1073741823, 0, 0, 0);
        run_random(250);

        // small position weights so scores straddle the threshold
        load_regs(16'd1, 16'd1, 16'd10, 16'd5, 16'd3, 16'd2, 48'd60000);
        run_random(350);

        load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 48'({$urandom, $urandom}));
        run_random(300);

        load_regs(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 48'd200);
        run_random(250);

        load_regs(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  48'(1) << $urandom_range(10, 47));
        run_random(250);

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
design/svms_pkg.sv
design/self_vehicle_match_score.sv
design/svms_check.sv
test/svms_checker.sv
test/tb_self_vehicle_match_score.sv
